>>> rtl/core/assert_macros.svh
// Assertion macros for the RTL files of the button classifier.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/bdpc_pkg.sv
// Shared types and constants for the button debounce / press classifier.
// No dependencies; used by every module of the block.
`default_nettype none

package bdpc_pkg;

  localparam int unsigned CNT_W   = 4;
  localparam int unsigned ACCUM_W = 32;
  localparam int unsigned CFG_W   = 32;

  localparam logic [CNT_W-1:0]   DEBOUNCE_SAMPLES_RST = 4'd5;
  localparam logic [ACCUM_W-1:0] HOLD_TICKS_RST       = 32'd1000;
  localparam logic [ACCUM_W-1:0] ACCUM_MAX            = 32'hFFFF_FFFF;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_DEBOUNCE_SAMPLES = 1'b0,
    REG_HOLD_TICKS       = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_SHORT = 2'd1,
    EV_LONG  = 2'd2
  } event_t;

  typedef enum logic [1:0] {
    ST_RELEASED = 2'd0,
    ST_PRESSED  = 2'd1,
    ST_HELD     = 2'd2
  } press_state_t;

  // one poll handed from the debouncer to the press machine
  typedef struct packed {
    logic en;
    logic pressed;
  } step_t;

  // press machine status back to the top level
  typedef struct packed {
    press_state_t state;
    event_t       ev;
  } fsm_status_t;

endpackage

`default_nettype wire

>>> rtl/core/bdpc_debounce.sv
// Stability counter and debounced pressed flag for the button classifier.
// Depends on bdpc_pkg.
`default_nettype none

module bdpc_debounce (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      en,
  input  wire logic                      sample,
  input  wire logic [bdpc_pkg::CNT_W-1:0] samples,
  output bdpc_pkg::step_t                step
);

  logic                       last_raw_r, last_raw_nxt;
  logic [bdpc_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                       pressed_r, pressed_nxt;
  logic [bdpc_pkg::CNT_W:0]   cnt_inc;

  // count equal samples, clamp at the threshold and take the level there
  always_comb begin
    cnt_inc = (sample == last_raw_r) ? ({1'b0, cnt_r} + 1'b1) : {{bdpc_pkg::CNT_W{1'b0}}, 1'b1};
    last_raw_nxt = sample;
    if (cnt_inc >= {1'b0, samples}) begin
      cnt_nxt     = samples;
      pressed_nxt = ~sample;
    end else begin
      cnt_nxt     = cnt_inc[bdpc_pkg::CNT_W-1:0];
      pressed_nxt = pressed_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_raw_r <= 1'b0;
      cnt_r      <= '0;
      pressed_r  <= 1'b0;
    end else if (en) begin
      last_raw_r <= last_raw_nxt;
      cnt_r      <= cnt_nxt;
      pressed_r  <= pressed_nxt;
    end
  end

  // the level settled on this poll acts on this poll
  assign step.en      = en;
  assign step.pressed = pressed_nxt;

endmodule

`default_nettype wire

>>> rtl/core/bdpc_press_fsm.sv
// Released / pressed / held machine with saturating pressed-time accumulator.
// Depends on bdpc_pkg.
`default_nettype none

module bdpc_press_fsm #(
  parameter int unsigned TICK_WIDTH = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire bdpc_pkg::step_t             step,
  input  wire logic [TICK_WIDTH-1:0]       tick,
  input  wire logic [bdpc_pkg::ACCUM_W-1:0] hold_ticks,
  output bdpc_pkg::fsm_status_t            status
);

  localparam int unsigned SUM_W =
    ((TICK_WIDTH > bdpc_pkg::ACCUM_W) ? TICK_WIDTH : bdpc_pkg::ACCUM_W) + 1;

  bdpc_pkg::press_state_t         state_r, state_nxt;
  logic [bdpc_pkg::ACCUM_W-1:0]   accum_r, accum_nxt;
  logic [TICK_WIDTH-1:0]          last_tick_r, last_tick_nxt;
  logic [TICK_WIDTH-1:0]          diff;
  logic [SUM_W-1:0]               sum;
  logic                           below_hold;
  bdpc_pkg::event_t               ev;

  // elapsed ticks wrap modulo 2^TICK_WIDTH; the sum saturates
  assign diff       = tick - last_tick_r;
  assign sum        = SUM_W'(accum_r) + SUM_W'(diff);
  assign below_hold = (accum_r < hold_ticks);

  // next state
  always_comb begin
    state_nxt = state_r;
    if (step.pressed) begin
      case (state_r)
        bdpc_pkg::ST_RELEASED: state_nxt = bdpc_pkg::ST_PRESSED;
        bdpc_pkg::ST_PRESSED:  if (!below_hold) state_nxt = bdpc_pkg::ST_HELD;
        default:               state_nxt = state_r;
      endcase
    end else begin
      state_nxt = bdpc_pkg::ST_RELEASED;
    end
  end

  // event, accumulator and tick mark
  always_comb begin
    ev            = bdpc_pkg::EV_NONE;
    accum_nxt     = accum_r;
    last_tick_nxt = last_tick_r;
    if (step.pressed) begin
      case (state_r)
        bdpc_pkg::ST_RELEASED: begin
          accum_nxt     = bdpc_pkg::ACCUM_W'(1);
          last_tick_nxt = tick;
        end
        bdpc_pkg::ST_PRESSED: begin
          if (below_hold) begin
            if (sum > SUM_W'(bdpc_pkg::ACCUM_MAX)) begin
              accum_nxt = bdpc_pkg::ACCUM_MAX;
            end else begin
              accum_nxt = sum[bdpc_pkg::ACCUM_W-1:0];
            end
            last_tick_nxt = tick;
          end else begin
            ev = bdpc_pkg::EV_LONG;
          end
        end
        default: ev = bdpc_pkg::EV_NONE;
      endcase
    end else begin
      case (state_r)
        bdpc_pkg::ST_RELEASED: accum_nxt = accum_r;
        bdpc_pkg::ST_PRESSED: begin
          ev        = bdpc_pkg::EV_SHORT;
          accum_nxt = '0;
        end
        default: accum_nxt = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bdpc_pkg::ST_RELEASED;
      accum_r     <= '0;
      last_tick_r <= '0;
    end else if (step.en) begin
      state_r     <= state_nxt;
      accum_r     <= accum_nxt;
      last_tick_r <= last_tick_nxt;
    end
  end

  assign status.state = state_r;
  assign status.ev    = ev;

endmodule

`default_nettype wire

>>> rtl/core/button_debounce_press_classifier_top.sv
// Top level of the button debounce / short-long press classifier.
// Depends on bdpc_pkg, bdpc_debounce, bdpc_press_fsm and assert_macros.svh.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------
//   in      | sink      | in_valid / in_stall  | in_raw_level, in_tick_now
//   out     | source    | out_valid / out_stall| out_event_code
//   cfg     | sink      | cfg_we               | cfg_index, cfg_wdata
//
// One poll per cycle unless in_stall holds: a request lands in the input
// register, is classified against the debouncer and press machine, and its
// event moves into the output register, from where it is taken.
// in_stall rises only when both registers are full and out_stall holds.
// rst_n is synchronous; configuration returns to 5 samples and 1000 ticks.
`default_nettype none

`include "assert_macros.svh"

module button_debounce_press_classifier_top #(
  parameter int unsigned TICK_WIDTH = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        in_raw_level,
  input  wire logic [TICK_WIDTH-1:0]       in_tick_now,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [1:0]                       out_event_code,
  input  wire logic                        cfg_we,
  input  wire logic [0:0]                  cfg_index,
  input  wire logic [bdpc_pkg::CFG_W-1:0]  cfg_wdata
);

  logic [bdpc_pkg::CNT_W-1:0]   debounce_samples_r;
  logic [bdpc_pkg::ACCUM_W-1:0] hold_ticks_r;

  logic                  a_valid_r;
  logic                  a_raw_r;
  logic [TICK_WIDTH-1:0] a_tick_r;
  logic                  out_valid_r;
  bdpc_pkg::event_t      out_event_r;
  logic                  adv;

  bdpc_pkg::step_t       step;
  bdpc_pkg::fsm_status_t status;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_samples_r <= bdpc_pkg::DEBOUNCE_SAMPLES_RST;
      hold_ticks_r       <= bdpc_pkg::HOLD_TICKS_RST;
    end else if (cfg_we) begin
      case (bdpc_pkg::cfg_reg_t'(cfg_index))
        bdpc_pkg::REG_DEBOUNCE_SAMPLES:
          debounce_samples_r <= cfg_wdata[bdpc_pkg::CNT_W-1:0];
        bdpc_pkg::REG_HOLD_TICKS:
          hold_ticks_r <= cfg_wdata[bdpc_pkg::ACCUM_W-1:0];
        default: hold_ticks_r <= hold_ticks_r;
      endcase
    end
  end

  // a poll moves on when the output register is free or being emptied
  assign adv      = a_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = a_valid_r && !adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (!in_stall) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      a_raw_r  <= in_raw_level;
      a_tick_r <= in_tick_now;
    end
  end

  bdpc_debounce u_debounce (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .sample  (a_raw_r),
    .samples (debounce_samples_r),
    .step    (step)
  );

  bdpc_press_fsm #(
    .TICK_WIDTH (TICK_WIDTH)
  ) u_press_fsm (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .tick       (a_tick_r),
    .hold_ticks (hold_ticks_r),
    .status     (status)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_event_r <= status.ev;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_event_code = out_event_r;

  // checks
  `ASSERT_NEXT(a_adv_gives_result, clk, rst_n, adv, out_valid_r,
    "processed poll did not reach the result register")
  `ASSERT_NEXT(a_long_enters_held, clk, rst_n,
    adv && (status.ev == bdpc_pkg::EV_LONG), status.state == bdpc_pkg::ST_HELD,
    "long hold reported without entering held")
  `ASSERT_IMPLIES(a_short_from_pressed, clk, rst_n,
    adv && (status.ev == bdpc_pkg::EV_SHORT), status.state == bdpc_pkg::ST_PRESSED,
    "short press reported outside the pressed state")

endmodule

`default_nettype wire

>>> tb/tb_button_debounce_press_classifier_top.sv
// Self-checking testbench for button_debounce_press_classifier_top.
// Depends on bdpc_pkg and the block's RTL. Polls are predicted in the bench and
// each event is checked in order of acceptance.
module tb_button_debounce_press_classifier_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned HOLD_OFF_LEN = 300;

  typedef enum int unsigned {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic                       in_raw_level = 1'b1;
  logic [31:0]                in_tick_now = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [1:0]                 out_event_code;
  logic                       cfg_we = 1'b0;
  logic [0:0]                 cfg_index = '0;
  logic [bdpc_pkg::CFG_W-1:0] cfg_wdata = '0;

  button_debounce_press_classifier_top #(.TICK_WIDTH(32)) uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_raw_level  (in_raw_level),
    .in_tick_now   (in_tick_now),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_event_code(out_event_code),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  always #2 clk = ~clk;

  // Predictor state and its copy of the configuration
  logic [3:0]             need_samples;
  logic [31:0]            long_thresh;
  logic                   pin_prev;
  int unsigned            same_run;
  logic                   level_down;
  bdpc_pkg::press_state_t machine;
  logic [31:0]            dwell_ticks;
  logic [31:0]            tick_mark;

  bdpc_pkg::event_t       expected_events[$];
  int unsigned            fail_count = 0;
  int unsigned            cycle_count = 0;
  logic [31:0]            cur_tick = '0;

  // Sender idling and receiver hold-off requests
  int unsigned  burst_left = 0;
  bit           gaps_off = 1'b0;
  int unsigned  pressure_reqs = 0;

  // Debounce first, then the press machine, on one poll
  function automatic bdpc_pkg::event_t classify_poll(input logic raw,
                                                     input logic [31:0] now);
    bdpc_pkg::event_t ev;
    logic [31:0]      diff;
    logic [31:0]      room;
    ev = bdpc_pkg::EV_NONE;
    if (raw == pin_prev) begin
      same_run = same_run + 1;
    end else begin
      same_run = 1;
      pin_prev = raw;
    end
    if (same_run >= 32'(need_samples)) begin
      same_run   = 32'(need_samples);
      level_down = (pin_prev == 1'b0);
    end
    if (level_down) begin
      if (machine == bdpc_pkg::ST_RELEASED) begin
        machine     = bdpc_pkg::ST_PRESSED;
        tick_mark   = now;
        dwell_ticks = 32'd1;
      end else if (machine == bdpc_pkg::ST_PRESSED) begin
        if (dwell_ticks < long_thresh) begin
          diff = now - tick_mark;
          room = bdpc_pkg::ACCUM_MAX - dwell_ticks;
          if (diff > room) dwell_ticks = bdpc_pkg::ACCUM_MAX;
          else dwell_ticks = dwell_ticks + diff;
          tick_mark = now;
        end else begin
          machine = bdpc_pkg::ST_HELD;
          ev      = bdpc_pkg::EV_LONG;
        end
      end
    end else begin
      // short press only from pressed; a release from held is silent
      if (machine == bdpc_pkg::ST_PRESSED) ev = bdpc_pkg::EV_SHORT;
      machine     = bdpc_pkg::ST_RELEASED;
      if (ev == bdpc_pkg::EV_SHORT || dwell_ticks != 0) dwell_ticks = '0;
    end
    return ev;
  endfunction

  // Offer one poll, wait for it to be taken, then maybe idle a while
  task automatic send_poll(input logic raw, input logic [31:0] tick);
    int unsigned gap;
    in_valid     <= 1'b1;
    in_raw_level <= raw;
    in_tick_now  <= tick;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_events.push_back(classify_poll(raw, tick));
    if (gaps_off || burst_left > 0) begin
      if (burst_left > 0) burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 250)
                                               : $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Stop offering and let every outstanding request come back
  task automatic drain_block();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input bdpc_pkg::cfg_reg_t idx, input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == bdpc_pkg::REG_DEBOUNCE_SAMPLES) need_samples = value[3:0];
    else long_thresh = value;
  endtask

  // Upper bits of the sample count are junk; only the low nibble counts
  task automatic set_config(input logic [3:0] samples, input logic [31:0] hold);
    drain_block();
    write_reg(bdpc_pkg::REG_DEBOUNCE_SAMPLES, {28'($urandom), samples});
    write_reg(bdpc_pkg::REG_HOLD_TICKS, hold);
  endtask

  task automatic hold_level(input logic raw, input int unsigned polls,
                            input int unsigned max_step);
    repeat (polls) begin
      cur_tick = cur_tick + $urandom_range(0, max_step);
      send_poll(raw, cur_tick);
    end
  endtask

  // Mostly whole presses with bounce around them, some plain noise
  task automatic press_traffic(input int unsigned n_items, input int unsigned max_step);
    int unsigned sent;
    int unsigned n;
    int unsigned press_len;
    int unsigned rel_len;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 6);
        repeat (n) send_poll(1'($urandom_range(0, 1)), $urandom);
        sent += n;
      end else begin
        n = $urandom_range(0, 3);
        repeat (n) send_poll(1'($urandom_range(0, 1)), cur_tick);
        press_len = 32'(need_samples) + $urandom_range(0, 16);
        rel_len   = 32'(need_samples) + $urandom_range(0, 4);
        hold_level(1'b0, press_len, max_step);
        hold_level(1'($urandom_range(0, 1)), $urandom_range(0, 2), max_step);
        hold_level(1'b1, rel_len, max_step);
        sent += n + press_len + rel_len;
      end
    end
  endtask

  // Pin low straight out of reset, defaults in force, then a short press
  task automatic test_reset_level();
    hold_level(1'b0, 6, 1);
    hold_level(1'b1, 6, 1);
  endtask

  // No debounce and no threshold: press, long hold, held, silent release
  task automatic test_zero_settings();
    set_config(4'd0, 32'd0);
    send_poll(1'b0, 32'd10);
    send_poll(1'b0, 32'd11);
    send_poll(1'b0, 32'd12);
    send_poll(1'b1, 32'd13);
  endtask

  // Tick wrap, accumulator saturation at the largest threshold
  task automatic test_wrap_saturation();
    set_config(4'd1, 32'hFFFF_FFFF);
    send_poll(1'b0, 32'hFFFF_FFF0);
    send_poll(1'b0, 32'h0000_0005);
    send_poll(1'b0, 32'h8000_0000);
    send_poll(1'b0, 32'h7FFF_FFFF);
    send_poll(1'b0, 32'h7FFF_FFFF);
    send_poll(1'b0, 32'h0000_0000);
    send_poll(1'b1, 32'h0000_0001);
  endtask

  task automatic test_random_phases();
    set_config(4'd1, 32'd1);
    cur_tick = $urandom;
    press_traffic(200, 3);
    set_config(4'd15, 32'd40);
    press_traffic(250, 20);
    set_config(4'd0, 32'd0);
    press_traffic(150, 5);
    set_config(4'd3, 32'd1000);
    press_traffic(250, 200);
    set_config(4'd2, 32'hFFFF_FFFF);
    press_traffic(150, 32'h7FFF_FFFF);
    set_config(4'($urandom_range(1, 15)), $urandom_range(1, 60));
    press_traffic(350, 15);
  endtask

  // Receiver holds off for a long stretch while polls keep coming
  task automatic test_backpressure();
    set_config(4'd4, 32'd25);
    gaps_off = 1'b1;
    pressure_reqs++;
    press_traffic(80, 10);
    gaps_off = 1'b0;
  endtask

  // Receiver stall: long hold-off on request, otherwise a changing pattern
  always @(posedge clk) begin : stall_gen
    static int unsigned pressure_seen = 0;
    static int unsigned hold_left = 0;
    static int unsigned mode_left = 0;
    static int unsigned stall_phase = 0;
    static stall_mode_t stall_mode = STALL_NONE;
    if (pressure_reqs != pressure_seen) begin
      pressure_seen = pressure_reqs;
      hold_left     = HOLD_OFF_LEN;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        mode_left  = $urandom_range(16, 128);
      end
      mode_left--;
      stall_phase++;
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 1) == 0);
        default:     out_stall <= ((stall_phase % 5) < 2);
      endcase
    end
  end

  // Compare each event taken against the oldest prediction
  always @(posedge clk) begin : event_check
    bdpc_pkg::event_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_events.size() == 0) begin
        $error("event_code: expected none, got %0d", out_event_code);
        fail_count++;
      end else begin
        want = expected_events.pop_front();
        if (out_event_code !== want) begin
          $error("event_code: expected %0d, got %0d", want, out_event_code);
          fail_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    need_samples = bdpc_pkg::DEBOUNCE_SAMPLES_RST;
    long_thresh  = bdpc_pkg::HOLD_TICKS_RST;
    pin_prev     = 1'b0;
    same_run     = 0;
    level_down   = 1'b0;
    machine      = bdpc_pkg::ST_RELEASED;
    dwell_ticks  = '0;
    tick_mark    = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_level();
    test_zero_settings();
    test_wrap_saturation();
    test_random_phases();
    test_backpressure();
    drain_block();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
